// ===== rtl/wdsr_pkg.sv =====
// Shared types and constants of the waveform decimator.
// Used by every module under waveform_decimate_to_screen_rows; depends on nothing.
package wdsr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ROW_W       = 8;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 21;
    localparam int AMP_W       = 16;
    localparam int POS_W       = 20;
    localparam int DIFF_W      = 32;
    localparam int MAG_W       = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [POS_W-1:0] POS_MAX   = 20'hFFFFF;
    localparam logic [CNT_W-1:0] MAX_COUNT = 21'd1048576;

    // Register indexes of the configuration port.
    localparam logic CFG_SAMPLE_COUNT = 1'b0;
    localparam logic CFG_AMPLITUDE    = 1'b1;

    // One picked sample on its way from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           idx;
        logic                       last;
    } t_point;

endpackage

// ===== rtl/wdsr_front.sv =====
// Front part: frame counters and the exact pick rule for each incoming sample.
// Depends on wdsr_pkg; feeds picked samples into wdsr_queue.
module wdsr_front #(
    parameter int POINTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [wdsr_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_frame_start,
    input  logic [wdsr_pkg::CNT_W-1:0]        i_sample_count,
    input  logic                              i_q_full,
    output logic                              o_push,
    output wdsr_pkg::t_point                  o_point
);
    import wdsr_pkg::*;

    localparam int PP_W = $clog2(POINTS + 1);
    localparam logic signed [DIFF_W-1:0] STEP = DIFF_W'(POINTS);

    // r_diff tracks point_position * sample_count - sample_position * POINTS.
    // A sample is picked when this lies in 0 .. POINTS-1.
    logic [POS_W-1:0]         r_spos, n_spos, spos_c;
    logic [PP_W-1:0]          r_pp, n_pp, pp_c;
    logic signed [DIFF_W-1:0] r_diff, n_diff, diff_c, add_c, sub_c;
    logic                     accept, pick;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Frame start clears the counters before the sample is examined.
    always_comb begin
        spos_c = i_frame_start ? '0 : r_spos;
        pp_c   = i_frame_start ? '0 : r_pp;
        diff_c = i_frame_start ? '0 : r_diff;
        pick   = (pp_c < PP_W'(POINTS)) && !diff_c[DIFF_W-1] && (diff_c < STEP);
        add_c  = pick ? DIFF_W'(i_sample_count) : '0;
        sub_c  = (spos_c < POS_MAX) ? STEP : '0;
        n_diff = diff_c + add_c - sub_c;
        n_pp   = pick ? pp_c + PP_W'(1) : pp_c;
        n_spos = (spos_c < POS_MAX) ? spos_c + POS_W'(1) : spos_c;
    end

    assign o_push         = accept && pick;
    assign o_point.sample = i_sample;
    assign o_point.idx    = IDX_W'(pp_c);
    assign o_point.last   = (pp_c == PP_W'(POINTS - 1));

    // Counter update on every transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spos <= '0;
            r_pp   <= '0;
            r_diff <= '0;
        end else if (accept) begin
            r_spos <= n_spos;
            r_pp   <= n_pp;
            r_diff <= n_diff;
        end
    end

endmodule

// ===== rtl/wdsr_queue.sv =====
// Short queue of picked samples between the front and the back part.
// Depends on wdsr_pkg for the entry type and depth.
module wdsr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wdsr_pkg::t_point i_point,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output wdsr_pkg::t_point o_point
);
    import wdsr_pkg::*;

    t_point              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_count;
    logic                do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_point = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_point;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

// ===== rtl/wdsr_back.sv =====
// Back part: scales a picked sample to a screen row with a serial divider
// and holds the result in the output register. Depends on wdsr_pkg.
module wdsr_back #(
    parameter int HEIGHT = 200
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [wdsr_pkg::AMP_W-1:0]    i_amplitude,
    input  logic                          i_q_valid,
    input  wdsr_pkg::t_point              i_q_point,
    output logic                          o_pop,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [wdsr_pkg::ROW_W-1:0]    o_row,
    output logic [wdsr_pkg::IDX_W-1:0]    o_idx,
    output logic                          o_last
);
    import wdsr_pkg::*;

    localparam int HALF  = HEIGHT / 2;
    localparam int SPAN  = HALF - 2;
    localparam int SPAN2 = 2 * SPAN;
    localparam int QB    = 8;
    localparam int QM_W  = QB + 1;
    localparam int CNT_B = $clog2(QB + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_back_state;

    t_back_state                r_state;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_last;
    logic                       r_neg, r_ovf;
    logic [AMP_W-1:0]           r_rem;
    logic [QB-1:0]              r_low, r_q;
    logic [CNT_B-1:0]           r_cnt;
    logic                       r_ovalid;
    logic [ROW_W-1:0]           r_orow;
    logic [IDX_W-1:0]           r_oidx;
    logic                       r_olast;

    logic [SAMPLE_W:0]          abs_s;
    logic [MAG_W-1:0]           mag;
    logic [AMP_W:0]             rem2, dext;
    logic                       ge;
    logic [QM_W-1:0]            qm;
    logic [ROW_W-1:0]           qc, row;
    logic                       out_free;

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !r_ovalid || i_tready;
    assign dext     = {1'b0, i_amplitude};

    // Magnitude of sample * 2 * span.
    always_comb begin
        abs_s = r_sample[SAMPLE_W-1] ? -{r_sample[SAMPLE_W-1], r_sample}
                                     : {1'b0, r_sample};
        mag   = MAG_W'(abs_s) * MAG_W'(SPAN2);
    end

    // One restoring division step: the low eight quotient bits.
    always_comb begin
        rem2 = {r_rem, r_low[QB-1]};
        ge   = (rem2 >= dext);
    end

    // Truncated quotient toward zero, ceil for positive values, then clamp.
    always_comb begin
        qm = r_neg ? QM_W'(r_q) : QM_W'(r_q) + QM_W'(r_rem != '0);
        if (r_ovf || (qm > QM_W'(SPAN))) begin
            qc = ROW_W'(SPAN);
        end else begin
            qc = ROW_W'(qm);
        end
        if (i_amplitude <= AMP_W'(1)) begin
            row = ROW_W'(HALF);
        end else if (r_neg) begin
            row = ROW_W'(HALF) + qc;
        end else begin
            row = ROW_W'(HALF) - qc;
        end
    end

    // Sequencer of the scaling work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CNT_B'(QB - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the divider.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_sample <= i_q_point.sample;
            r_idx    <= i_q_point.idx;
            r_last   <= i_q_point.last;
        end
        if (r_state == S_MUL) begin
            r_neg <= r_sample[SAMPLE_W-1];
            r_rem <= mag[MAG_W-1:QB];
            r_low <= mag[QB-1:0];
            r_ovf <= ({1'b0, mag[MAG_W-1:QB]} >= dext);
            r_q   <= '0;
            r_cnt <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem <= ge ? AMP_W'(rem2 - dext) : AMP_W'(rem2);
            r_q   <= {r_q[QB-2:0], ge};
            r_low <= {r_low[QB-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_B'(1);
        end
    end

    // Output register; a finished row waits here for its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_orow  <= row;
            r_oidx  <= r_idx;
            r_olast <= r_last;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_row    = r_orow;
    assign o_idx    = r_oidx;
    assign o_last   = r_olast;

endmodule

// ===== rtl/waveform_decimate_to_screen_rows.sv =====
// Top level of the waveform decimator: configuration registers and the
// front, queue and back parts. Depends on wdsr_pkg, wdsr_front, wdsr_queue, wdsr_back.
//
// Samples arrive on the slave stream, one per transfer, with tuser marking the
// first sample of a frame. Of sample_count samples, POINTS are picked (point i
// takes sample floor(i*sample_count/POINTS)) and each is turned into a screen
// row, half - ceil(sample*2*(half-2)/amplitude_pp) clamped to 2 .. 2*half-2,
// or the centre row when amplitude_pp is at most one. In the back part a
// picked sample is loaded, multiplied, divided by the serial divider and
// dispatched, and the back part takes no new sample until it is through with
// the last; a four-entry queue lets the front keep taking samples meanwhile.
// The user must write registers through the plain write port only while no
// sample is in flight; the block itself does not enforce this.
module waveform_decimate_to_screen_rows #(
    parameter int POINTS = 256,
    parameter int HEIGHT = 200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [20:0] i_cfg_data,
    // Sample stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tuser,   // [0] frame_start
    // Point stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] pixel_row, [17:8] point_index, zero fill
    output logic        m_axis_tlast    // last_point
);
    import wdsr_pkg::*;

    localparam int HALF = HEIGHT / 2;

    logic [CNT_W-1:0] r_sample_count, n_sample_count;
    logic [AMP_W-1:0] r_amplitude;
    logic             q_full, q_valid, push, pop;
    t_point           push_point, head_point;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] idx;

    // Frame length saturates into POINTS .. 2^20.
    always_comb begin
        if (i_cfg_data < CNT_W'(POINTS)) begin
            n_sample_count = CNT_W'(POINTS);
        end else if (i_cfg_data > MAX_COUNT) begin
            n_sample_count = MAX_COUNT;
        end else begin
            n_sample_count = i_cfg_data;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= CNT_W'(1024);
            r_amplitude    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_COUNT: r_sample_count <= n_sample_count;
                CFG_AMPLITUDE:    r_amplitude    <= i_cfg_data[AMP_W-1:0];
                default:          r_amplitude    <= r_amplitude;
            endcase
        end
    end

    wdsr_front #(
        .POINTS (POINTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_sample       (s_axis_tdata),
        .i_frame_start  (s_axis_tuser),
        .i_sample_count (r_sample_count),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_point        (push_point)
    );

    wdsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_point (push_point),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_point (head_point)
    );

    wdsr_back #(
        .HEIGHT (HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_amplitude (r_amplitude),
        .i_q_valid   (q_valid),
        .i_q_point   (head_point),
        .o_pop       (pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_row       (row),
        .o_idx       (idx),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, idx, row};

    // A delivered row always lies inside the drawing area.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (row >= ROW_W'(2)) && (row <= ROW_W'(2 * HALF - 2)))
        else $error("pixel row outside the drawing area");

    // The final point of a frame carries the last point index.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (idx == IDX_W'(POINTS - 1)))
        else $error("last point flagged on a wrong index");

    // The first sample of a frame is always picked.
    a_first_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |-> push)
        else $error("first sample of a frame was not picked");

endmodule

// ===== sim/tb_waveform_decimate_to_screen_rows.sv =====
// Self-checking testbench of waveform_decimate_to_screen_rows: directed and random
// frames are streamed in, each picked point is predicted and compared on transfer.
// Depends on wdsr_pkg and the RTL under rtl/.
module tb_waveform_decimate_to_screen_rows;
    timeunit 1ns;
    timeprecision 1ps;

    import wdsr_pkg::*;

    localparam int POINTS      = 256;
    localparam int HEIGHT      = 200;
    localparam int HALF_ROWS   = HEIGHT / 2;
    localparam int ROW_SPAN    = HALF_ROWS - 2;
    localparam int COUNT_CEIL  = 1048576;
    localparam int SAMPLE_POS_TOP = 20'hFFFFF;
    localparam int SETTLE_CYCLES  = 20;
    localparam int TAIL_CYCLES    = 50;
    localparam int STALL_CYCLES   = 400;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RANDOM_SAMPLES = 1500;

    // One expected point on the output stream.
    typedef struct {
        logic [ROW_W-1:0] pixel_row;
        logic [IDX_W-1:0] point_index;
        logic             last_point;
    } t_screen_point;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = CFG_SAMPLE_COUNT;
    logic [CNT_W-1:0]  i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata = '0;   // [15:0] sample
    logic              s_axis_tuser = 1'b0; // [0] frame_start
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;        // [7:0] pixel_row, [17:8] point_index
    logic              m_axis_tlast;        // last_point

    // Predictor copy of the registers and the frame counters.
    logic [CNT_W-1:0]  frame_length;
    logic [AMP_W-1:0]  amplitude;
    logic [POS_W-1:0]  sample_pos;
    int                points_done;
    logic [30:0]       pick_target;

    t_screen_point     pending_points[$];
    t_screen_point     want;
    int                error_count = 0;
    int                cycle_count = 0;
    bit                src_idle_en = 1'b1;
    logic              sink_idle_en = 1'b1;
    logic              sink_hold = 1'b0;
    logic              stall_req = 1'b0;

    waveform_decimate_to_screen_rows #(
        .POINTS(POINTS),
        .HEIGHT(HEIGHT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Screen row of one sample under the current amplitude setting.
    function automatic logic [ROW_W-1:0] screen_row(input logic signed [SAMPLE_W-1:0] smp);
        longint scaled;
        longint divisor;
        longint offset;
        if (amplitude <= 1)
            return ROW_W'(HALF_ROWS);
        scaled  = longint'(smp) * (2 * ROW_SPAN);
        divisor = longint'(amplitude);
        offset  = scaled / divisor;
        // Round the quotient up for positive values that do not divide evenly.
        if (scaled > 0 && (scaled % divisor) != 0)
            offset = offset + 1;
        if (offset > ROW_SPAN)
            offset = ROW_SPAN;
        if (offset < -ROW_SPAN)
            offset = -ROW_SPAN;
        return ROW_W'(HALF_ROWS - offset);
    endfunction

    // Advance the frame counters by one accepted sample and queue its point, if picked.
    function automatic void decimate_sample(input logic signed [SAMPLE_W-1:0] smp,
                                            input logic frame_start);
        t_screen_point pt;
        if (frame_start) begin
            sample_pos  = '0;
            points_done = 0;
            pick_target = '0;
        end
        if (points_done < POINTS && 31'(sample_pos) == pick_target / POINTS) begin
            pt.pixel_row   = screen_row(smp);
            pt.point_index = IDX_W'(points_done);
            pt.last_point  = (points_done == POINTS - 1);
            pending_points.push_back(pt);
            points_done = points_done + 1;
            pick_target = pick_target + 31'(frame_length);
        end
        if (sample_pos < SAMPLE_POS_TOP)
            sample_pos = sample_pos + 1'b1;
    endfunction

    // Register update as the block applies it, with saturation of the frame length.
    function automatic void apply_register(input logic idx, input logic [CNT_W-1:0] value);
        if (idx == CFG_SAMPLE_COUNT) begin
            if (value < POINTS)
                frame_length = CNT_W'(POINTS);
            else if (value > COUNT_CEIL)
                frame_length = CNT_W'(COUNT_CEIL);
            else
                frame_length = value;
        end else begin
            amplitude = value[AMP_W-1:0];
        end
    endfunction

    // Receiver: random back-pressure and field-by-field comparison of each transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected point: pixel_row %0d point_index %0d last_point %0b",
                       m_axis_tdata[7:0], m_axis_tdata[17:8], m_axis_tlast);
                error_count = error_count + 1;
            end else begin
                want = pending_points.pop_front();
                if (m_axis_tdata[7:0] !== want.pixel_row) begin
                    $error("pixel_row: expected %0d, actual %0d",
                           want.pixel_row, m_axis_tdata[7:0]);
                    error_count = error_count + 1;
                end
                if (m_axis_tdata[17:8] !== want.point_index) begin
                    $error("point_index: expected %0d, actual %0d",
                           want.point_index, m_axis_tdata[17:8]);
                    error_count = error_count + 1;
                end
                if (m_axis_tlast !== want.last_point) begin
                    $error("last_point: expected %0b, actual %0b",
                           want.last_point, m_axis_tlast);
                    error_count = error_count + 1;
                end
            end
        end
        if (sink_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !sink_idle_en || ($urandom_range(99) >= 29);
    end

    // Long receiver hold-off, counted here once requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req <= 1'b0;
                sink_hold <= 1'b1;
                repeat (STALL_CYCLES) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
        end
    end

    // Offer one sample and wait for its transfer; valid stays high for a following sample.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic frame_start);
        while (src_idle_en && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= frame_start;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        decimate_sample(smp, frame_start);
    endtask

    // Stop offering, then wait for every expected point and a quiet pause.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [CNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        apply_register(idx, value);
        i_cfg_we <= 1'b0;
    endtask

    // Sample mostly within the amplitude range, sometimes anywhere in the field.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        int reach;
        reach = (amplitude > 32767) ? 32767 : int'(amplitude);
        if (reach > 0 && $urandom_range(99) < 70)
            return SAMPLE_W'(int'($urandom_range(2 * reach, 0)) - reach);
        return SAMPLE_W'($urandom);
    endfunction

    // Without any frame start the first sample counts as sample zero; amplitude zero
    // puts every point on the centre row.
    task automatic test_no_frame_start_after_reset();
        repeat (5) send_sample(SAMPLE_W'($urandom), 1'b0);
        settle();
    endtask

    // Frame length written below the minimum, amplitude of one count.
    task automatic test_small_amplitude();
        write_register(CFG_SAMPLE_COUNT, '0);
        write_register(CFG_AMPLITUDE, 21'd1);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        settle();
    endtask

    // Extreme samples against the smallest and the largest useful amplitude.
    task automatic test_sample_extremes();
        write_register(CFG_AMPLITUDE, 21'd2);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        settle();
        write_register(CFG_AMPLITUDE, 21'hFFFF);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        settle();
    endtask

    // A new frame length takes effect from the point after the next picked one.
    task automatic test_count_change_mid_frame();
        write_register(CFG_SAMPLE_COUNT, 21'd256);
        write_register(CFG_AMPLITUDE, 21'd700);
        repeat (4) send_sample(random_sample(), 1'b0);
        settle();
        write_register(CFG_SAMPLE_COUNT, 21'd1000);
        send_sample(random_sample(), 1'b0);
        repeat (5) send_sample(random_sample(), 1'b0);
        settle();
    endtask

    // Frame length written above the maximum; only the first point falls in the samples sent.
    task automatic test_largest_frame();
        write_register(CFG_SAMPLE_COUNT, 21'h1FFFFF);
        write_register(CFG_AMPLITUDE, 21'd300);
        send_sample(random_sample(), 1'b1);
        repeat (40) send_sample(random_sample(), 1'b0);
        settle();
    endtask

    // Receiver holds off for a long time while a full frame is offered back to back.
    task automatic test_output_stall();
        write_register(CFG_SAMPLE_COUNT, 21'd256);
        write_register(CFG_AMPLITUDE, 21'd500);
        src_idle_en = 1'b0;
        stall_req <= 1'b1;
        send_sample(random_sample(), 1'b1);
        repeat (299) send_sample(random_sample(), 1'b0);
        src_idle_en = 1'b1;
        settle();
    endtask

    // Random settings and frames: mostly whole frames with a few samples past the end,
    // some cut short, some with stray frame starts.
    task automatic test_random_frames();
        int sent;
        int frame_no;
        int pick;
        int frame_len;
        logic [CNT_W-1:0] length_value;
        sent     = 0;
        frame_no = 0;
        while (sent < RANDOM_SAMPLES) begin
            pick = $urandom_range(99);
            if (pick < 60)
                length_value = CNT_W'($urandom_range(600, 256));
            else if (pick < 80)
                length_value = CNT_W'($urandom_range(2000, 601));
            else if (pick < 92)
                length_value = CNT_W'($urandom_range(255, 0));
            else if (pick < 96)
                length_value = CNT_W'(COUNT_CEIL);
            else
                length_value = CNT_W'($urandom_range(2097151, COUNT_CEIL + 1));
            if ($urandom_range(99) < 80 || frame_no == 0)
                write_register(CFG_SAMPLE_COUNT, length_value);
            if ($urandom_range(99) < 80 || frame_no == 0) begin
                pick = $urandom_range(99);
                if (pick < 10)
                    write_register(CFG_AMPLITUDE, CNT_W'($urandom_range(1, 0)));
                else if (pick < 20)
                    write_register(CFG_AMPLITUDE, 21'hFFFF);
                else if (pick < 30)
                    write_register(CFG_AMPLITUDE, CNT_W'($urandom_range(15, 2)));
                else
                    write_register(CFG_AMPLITUDE, CNT_W'($urandom_range(65535, 16)));
            end
            // One frame runs with no idling on either side.
            src_idle_en = (frame_no != 2);
            sink_idle_en <= (frame_no != 2);
            if ($urandom_range(99) < 75)
                frame_len = int'(frame_length) + $urandom_range(20, 0);
            else
                frame_len = $urandom_range(int'(frame_length), 1);
            if (frame_len > 1500)
                frame_len = 1500;
            send_sample(random_sample(), $urandom_range(99) < 95);
            for (int k = 1; k < frame_len; k++)
                send_sample(random_sample(), $urandom_range(99) < 1);
            sent = sent + frame_len;
            frame_no = frame_no + 1;
            settle();
        end
        src_idle_en = 1'b1;
        sink_idle_en <= 1'b1;
    endtask

    // Test sequence.
    initial begin
        frame_length = CNT_W'(1024);
        amplitude    = '0;
        sample_pos   = '0;
        points_done  = 0;
        pick_target  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_no_frame_start_after_reset();
        test_small_amplitude();
        test_sample_extremes();
        test_count_change_mid_frame();
        test_largest_frame();
        test_output_stall();
        test_random_frames();

        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
